// ===== sv/ted_pkg.sv =====
// Shared types and constants for the text encoding detector.
package ted_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ConfW = 7;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [1:0] EncUtf8    = 2'd0;
  localparam logic [1:0] EncUtf16Le = 2'd1;
  localparam logic [1:0] EncUtf16Be = 2'd2;
  localparam logic [1:0] EncLatin1  = 2'd3;

  localparam logic [ConfW-1:0] ConfBom    = 7'd100;
  localparam logic [ConfW-1:0] ConfUtf8   = 7'd90;
  localparam logic [ConfW-1:0] ConfLatin1 = 7'd30;

  localparam logic [23:0] BomUtf8    = 24'hEFBBBF;
  localparam logic [15:0] BomUtf16Le = 16'hFFFE;
  localparam logic [15:0] BomUtf16Be = 16'hFEFF;

  localparam logic [ByteW-1:0] ContLow  = 8'h80;
  localparam logic [ByteW-1:0] ContHigh = 8'hBF;

  typedef struct packed {
    logic [1:0]       encoding;
    logic             is_valid;
    logic [ConfW-1:0] confidence;
    logic [1:0]       bom_length;
  } res_t;

endpackage

// ===== sv/ted_intf.sv =====
// Request and result channel interfaces of the text encoding detector.
interface ted_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [ted_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface ted_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                encoding;
  logic                      is_valid;
  logic [ted_pkg::ConfW-1:0] confidence;
  logic [1:0]                bom_length;

  modport source (output valid, output encoding, output is_valid, output confidence,
                  output bom_length, input ready);
  modport sink (input valid, input encoding, input is_valid, input confidence,
                input bom_length, output ready);
endinterface

// ===== sv/ted_scan.sv =====
// Decoder state: prefix capture, length parity, UTF-8 check and verdict.
module ted_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      kind_i,
  input  logic [ted_pkg::ByteW-1:0] data_byte_i,
  output ted_pkg::res_t             res_o
);
  import ted_pkg::*;

  logic [23:0]      prefix_q, prefix_d;
  logic [1:0]       seen_q, seen_d;
  logic             odd_q, odd_d;
  logic [1:0]       pend_q, pend_d;
  logic [ByteW-1:0] low_q, low_d;
  logic [ByteW-1:0] high_q, high_d;
  logic             failed_q, failed_d;
  logic [15:0]      first2;

  always_comb begin
    prefix_d = prefix_q;
    seen_d   = seen_q;
    odd_d    = odd_q;
    pend_d   = pend_q;
    low_d    = low_q;
    high_d   = high_q;
    failed_d = failed_q;
    if (step_i && kind_i == KindEnd) begin
      prefix_d = '0;
      seen_d   = '0;
      odd_d    = 1'b0;
      pend_d   = '0;
      low_d    = ContLow;
      high_d   = ContHigh;
      failed_d = 1'b0;
    end else if (step_i) begin
      case (seen_q)
        2'd0:    prefix_d[23:16] = data_byte_i;
        2'd1:    prefix_d[15:8]  = data_byte_i;
        2'd2:    prefix_d[7:0]   = data_byte_i;
        default: prefix_d = prefix_q;
      endcase
      if (seen_q != 2'd3) begin
        seen_d = seen_q + 2'd1;
      end
      odd_d = ~odd_q;
      if (!failed_q) begin
        low_d  = ContLow;
        high_d = ContHigh;
        if (pend_q == 2'd0) begin
          if (data_byte_i inside {[8'h00:8'h7F]}) begin
            pend_d = 2'd0;
          end else if (data_byte_i inside {[8'hC2:8'hDF]}) begin
            pend_d = 2'd1;
          end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
            pend_d = 2'd2;
            if (data_byte_i == 8'hE0) low_d = 8'hA0;
            if (data_byte_i == 8'hED) high_d = 8'h9F;
          end else if (data_byte_i inside {[8'hF0:8'hF4]}) begin
            pend_d = 2'd3;
            if (data_byte_i == 8'hF0) low_d = 8'h90;
            if (data_byte_i == 8'hF4) high_d = 8'h8F;
          end else begin
            failed_d = 1'b1;
          end
        end else if (data_byte_i < low_q || data_byte_i > high_q) begin
          failed_d = 1'b1;
        end else begin
          pend_d = pend_q - 2'd1;
        end
      end
    end
  end

  assign first2 = prefix_q[23:8];

  always_comb begin
    if (seen_q == 2'd3 && prefix_q == BomUtf8) begin
      res_o = '{encoding: EncUtf8, is_valid: 1'b1, confidence: ConfBom, bom_length: 2'd3};
    end else if (seen_q >= 2'd2 && first2 == BomUtf16Le) begin
      res_o = '{encoding: EncUtf16Le, is_valid: ~odd_q, confidence: ConfBom,
                bom_length: 2'd2};
    end else if (seen_q >= 2'd2 && first2 == BomUtf16Be) begin
      res_o = '{encoding: EncUtf16Be, is_valid: ~odd_q, confidence: ConfBom,
                bom_length: 2'd2};
    end else if (!failed_q && pend_q == 2'd0) begin
      res_o = '{encoding: EncUtf8, is_valid: 1'b1, confidence: ConfUtf8, bom_length: 2'd0};
    end else if (seen_q != 2'd0) begin
      res_o = '{encoding: EncLatin1, is_valid: 1'b1, confidence: ConfLatin1,
                bom_length: 2'd0};
    end else begin
      res_o = '{encoding: EncUtf8, is_valid: 1'b1, confidence: ConfUtf8, bom_length: 2'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      seen_q   <= '0;
      odd_q    <= 1'b0;
      pend_q   <= '0;
      low_q    <= ContLow;
      high_q   <= ContHigh;
      failed_q <= 1'b0;
    end else begin
      prefix_q <= prefix_d;
      seen_q   <= seen_d;
      odd_q    <= odd_d;
      pend_q   <= pend_d;
      low_q    <= low_d;
      high_q   <= high_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ===== sv/text_encoding_detector_core.sv =====
// Top level of the text encoding detector: request register, decoder, result register.
//
// Usage: send a text as data requests (kind 0, one byte each) on in_i, then
// one end request (kind 1). The end request yields one result on out_o with
// the encoding, validity, confidence and byte order mark length; data
// requests yield no result. After the end request the decoder is back at its
// reset state, ready for the next text.
// Throughput: one request per cycle, set by the decoder update between the
// request register and the result register, unless an end request is held (see Stall).
// Result path: an end request goes from the request register through the
// decoder into the result register, and its result waits on out_o until taken.
// Reset: clears the valid flags of both registers and the decoder state; no result is pending.
// Stall: while a result waits on out_o, data requests keep flowing; a second
// end request holds in the request register, and in_i.ready drops only then.
module text_encoding_detector_core (
  input logic      clk_i,
  input logic      rst_ni,
  ted_req_if.sink  in_i,
  ted_res_if.source out_o
);
  import ted_pkg::*;

  logic             req_valid_q, req_valid_d;
  logic             req_kind_q;
  logic [ByteW-1:0] req_byte_q;
  logic             res_valid_q, res_valid_d;
  res_t             res_q;
  res_t             scan_res;
  logic             advance;
  logic             take;
  logic             emit;

  assign advance   = req_valid_q && (req_kind_q == KindData || !res_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || advance;
  assign take      = in_i.valid && in_i.ready;
  assign emit      = advance && req_kind_q == KindEnd;

  ted_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .kind_i      (req_kind_q),
    .data_byte_i (req_byte_q),
    .res_o       (scan_res)
  );

  always_comb begin
    req_valid_d = req_valid_q;
    if (take) begin
      req_valid_d = 1'b1;
    end else if (advance) begin
      req_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_kind_q <= in_i.kind;
      req_byte_q <= in_i.data_byte;
    end
    if (emit) begin
      res_q <= scan_res;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.encoding   = res_q.encoding;
  assign out_o.is_valid   = res_q.is_valid;
  assign out_o.confidence = res_q.confidence;
  assign out_o.bom_length = res_q.bom_length;

endmodule

// ===== bench/ted_checker.sv =====
// Scoreboard for the text encoding detector: predicts each verdict and compares results.
module ted_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ted_req_if   req_i,
  ted_res_if   res_i,
  output int   errors_o,
  output int   pending_o
);
  import ted_pkg::*;

  logic [23:0]      head_bytes;
  logic [1:0]       head_count;
  logic             odd_len;
  logic [1:0]       cont_due;
  logic [ByteW-1:0] cont_lo;
  logic [ByteW-1:0] cont_hi;
  logic             utf8_bad;

  res_t verdicts_q[$];
  int   mismatches;

  task automatic clear_text();
    head_bytes = '0;
    head_count = '0;
    odd_len    = 1'b0;
    cont_due   = '0;
    cont_lo    = ContLow;
    cont_hi    = ContHigh;
    utf8_bad   = 1'b0;
  endtask

  task automatic absorb_byte(input logic [ByteW-1:0] b);
    int sh;
    if (head_count < 2'd3) begin
      sh = 16 - 8 * int'(head_count);
      head_bytes = head_bytes | (24'(b) << sh);
      head_count = head_count + 2'd1;
    end
    odd_len = ~odd_len;
    if (!utf8_bad) begin
      if (cont_due == 2'd0) begin
        cont_lo = ContLow;
        cont_hi = ContHigh;
        if (b <= 8'h7F) begin
        end else if (b inside {[8'hC2:8'hDF]}) begin
          cont_due = 2'd1;
        end else if (b inside {[8'hE0:8'hEF]}) begin
          cont_due = 2'd2;
          if (b == 8'hE0) cont_lo = 8'hA0;
          if (b == 8'hED) cont_hi = 8'h9F;
        end else if (b inside {[8'hF0:8'hF4]}) begin
          cont_due = 2'd3;
          if (b == 8'hF0) cont_lo = 8'h90;
          if (b == 8'hF4) cont_hi = 8'h8F;
        end else begin
          utf8_bad = 1'b1;
        end
      end else begin
        if (b < cont_lo || b > cont_hi) begin
          utf8_bad = 1'b1;
        end else begin
          cont_due = cont_due - 2'd1;
        end
        cont_lo = ContLow;
        cont_hi = ContHigh;
      end
    end
  endtask

  function automatic res_t text_verdict();
    res_t r;
    r.is_valid = 1'b1;
    r.bom_length = 2'd0;
    if (head_count == 2'd3 && head_bytes == BomUtf8) begin
      r.encoding = EncUtf8;
      r.confidence = ConfBom;
      r.bom_length = 2'd3;
    end else if (head_count >= 2'd2 && head_bytes[23:8] == BomUtf16Le) begin
      r.encoding = EncUtf16Le;
      r.is_valid = ~odd_len;
      r.confidence = ConfBom;
      r.bom_length = 2'd2;
    end else if (head_count >= 2'd2 && head_bytes[23:8] == BomUtf16Be) begin
      r.encoding = EncUtf16Be;
      r.is_valid = ~odd_len;
      r.confidence = ConfBom;
      r.bom_length = 2'd2;
    end else if (!utf8_bad && cont_due == 2'd0) begin
      r.encoding = EncUtf8;
      r.confidence = ConfUtf8;
    end else if (head_count != 2'd0) begin
      r.encoding = EncLatin1;
      r.confidence = ConfLatin1;
    end else begin
      r.encoding = EncUtf8;
      r.confidence = ConfUtf8;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      clear_text();
      verdicts_q.delete();
      mismatches = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (verdicts_q.size() == 0) begin
          $error("result with no request pending: encoding %0d", res_i.encoding);
          mismatches++;
        end else begin
          want = verdicts_q.pop_front();
          if (res_i.encoding !== want.encoding) begin
            $error("encoding: expected %0d, got %0d", want.encoding, res_i.encoding);
            mismatches++;
          end
          if (res_i.is_valid !== want.is_valid) begin
            $error("is_valid: expected %0d, got %0d", want.is_valid, res_i.is_valid);
            mismatches++;
          end
          if (res_i.confidence !== want.confidence) begin
            $error("confidence: expected %0d, got %0d", want.confidence, res_i.confidence);
            mismatches++;
          end
          if (res_i.bom_length !== want.bom_length) begin
            $error("bom_length: expected %0d, got %0d", want.bom_length, res_i.bom_length);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.kind == KindEnd) begin
          verdicts_q.push_back(text_verdict());
          clear_text();
        end else begin
          absorb_byte(req_i.data_byte);
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= verdicts_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the text encoding detector bench: clock, reset, byte streams and verdict.
module testbench;
  import ted_pkg::*;

  localparam int unsigned TargetItems = 1800;
  localparam int unsigned CycleLimit  = 400000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   errors;
  int   pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit   tx_quiet;
  logic [ByteW-1:0] text_q[$];

  ted_req_if req_if ();
  ted_res_if res_if ();

  text_encoding_detector_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  ted_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .res_i     (res_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_req(input logic k, input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= k;
    req_if.data_byte <= b;
    do @(posedge clk); while (!req_if.ready);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_req(KindData, text_q[i]);
    send_req(KindEnd, 8'($urandom_range(0, 255)));
  endtask

  // Hold the sender until every verdict has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [ByteW-1:0] any_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  task automatic push_scalar();
    logic [ByteW-1:0] lead;
    case ($urandom_range(0, 4))
      0, 1: text_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
      2: begin
        text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        text_q.push_back(any_cont());
      end
      3: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        text_q.push_back(lead);
        if (lead == 8'hE0) text_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
        else if (lead == 8'hED) text_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
        else text_q.push_back(any_cont());
        text_q.push_back(any_cont());
      end
      default: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        text_q.push_back(lead);
        if (lead == 8'hF0) text_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
        else if (lead == 8'hF4) text_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
        else text_q.push_back(any_cont());
        text_q.push_back(any_cont());
        text_q.push_back(any_cont());
      end
    endcase
  endtask

  task automatic build_text();
    int unsigned n;
    int unsigned pick;
    logic [ByteW-1:0] marks[5];
    marks = '{8'hEF, 8'hBB, 8'hBF, 8'hFE, 8'hFF};
    text_q.delete();
    pick = $urandom_range(0, 9);
    n = $urandom_range(0, 8);
    case (pick)
      0, 1, 2, 3, 4: begin
        if ($urandom_range(0, 3) == 0) text_q = '{8'hEF, 8'hBB, 8'hBF};
        repeat (n) push_scalar();
      end
      5: begin
        if ($urandom_range(0, 1) == 0) text_q = '{8'hFF, 8'hFE};
        else text_q = '{8'hFE, 8'hFF};
        repeat ($urandom_range(0, 9)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      6: repeat ($urandom_range(0, 10)) text_q.push_back(8'($urandom_range(0, 255)));
      7: begin
        repeat (n + 1) push_scalar();
        if ($urandom_range(0, 1) == 0) begin
          text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (text_q.size() > 1) begin
          void'(text_q.pop_back());
        end else begin
          text_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
        end
        if ($urandom_range(0, 1) == 0) repeat (2) push_scalar();
      end
      8: begin
        repeat ($urandom_range(0, 2)) push_scalar();
        case ($urandom_range(0, 3))
          0: text_q.push_back(8'hE0);
          1: text_q.push_back(8'hED);
          2: text_q.push_back(8'hF0);
          default: text_q.push_back(8'hF4);
        endcase
        repeat ($urandom_range(1, 3)) text_q.push_back(any_cont());
        repeat ($urandom_range(0, 2)) push_scalar();
      end
      default: begin
        repeat ($urandom_range(1, 4)) text_q.push_back(marks[$urandom_range(0, 4)]);
        repeat ($urandom_range(0, 3)) push_scalar();
      end
    endcase
  endtask

  initial begin
    int unsigned next_pause;
    req_if.valid     <= 1'b0;
    req_if.kind      <= KindData;
    req_if.data_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_quiet = 1'b0;
    text_q = {};
    send_text();
    text_q = '{8'hEF, 8'hBB, 8'hBF};
    send_text();
    text_q = '{8'hFF, 8'hFE, 8'h00};
    send_text();
    text_q = '{8'hFE, 8'hFF};
    send_text();
    text_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    text_q = '{8'hE0, 8'h9F};
    send_text();
    text_q = '{8'hC1, 8'h7F, 8'hED, 8'hA0};
    send_text();
    drain();

    next_pause = 600;
    while (sent < TargetItems) begin
      if ($urandom_range(0, 5) == 0) tx_quiet = ~tx_quiet;
      build_text();
      send_text();
      if (sent >= next_pause) begin
        drain();
        next_pause += 600;
      end
    end
    drain();
    repeat (6) @(posedge clk);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    bit rx_quiet;
    rx_quiet = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) rx_quiet = ~rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

endmodule
